// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/siau_pkg.sv =====
// package with types, codes and constants of the signed integer alu
`default_nettype none
package siau_pkg;
  localparam int DataWidth = 32;
  localparam int Stages = DataWidth + 3;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_AND = 4'd4, OP_OR = 4'd5, OP_NOT = 4'd6, OP_XOR = 4'd7,
    OP_REM = 4'd8, OP_INC = 4'd9, OP_DEC = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_INVALID = 2'd2, ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0] operation;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result;
    logic [1:0] status;
  } out_item_t;

  // work carried down the divider pipeline
  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] dvs;
    logic                 neg_q;
    logic                 neg_r;
    logic                 is_div;
    logic [DataWidth-1:0] alt;
    logic                 use_alt;
    logic [1:0]           status;
  } div_work_t;
endpackage
`default_nettype wire

// ===== sv/siau_div_pipe.sv =====
// restoring divider, one quotient bit per pipeline stage, with simple ops riding along
`default_nettype none
module siau_div_pipe
  import siau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_work_t in_work,
  output logic      out_valid,
  output div_work_t out_work
);
  localparam int Steps = DataWidth;

  logic [Steps-1:0] valid;
  div_work_t        work [Steps];
  div_work_t        work_next [Steps];

  always_comb begin
    for (int i = 0; i < Steps; i++) begin
      div_work_t         w;
      logic [DataWidth:0] trial;
      w = (i == 0) ? in_work : work[i-1];
      trial = {1'b0, w.rem[DataWidth-2:0], w.quo[DataWidth-1]} - {1'b0, w.dvs};
      if (w.use_alt) begin
        work_next[i] = w;
      end else begin
        work_next[i] = w;
        work_next[i].quo = {w.quo[DataWidth-2:0], ~trial[DataWidth]};
        work_next[i].rem = trial[DataWidth] ? {w.rem[DataWidth-2:0], w.quo[DataWidth-1]}
                                            : trial[DataWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[Steps-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Steps; i++) work[i] <= work_next[i];
    end
  end

  assign out_valid = valid[Steps-1];
  assign out_work  = work[Steps-1];
endmodule
`default_nettype wire

// ===== sv/signed_integer_alu_core.sv =====
// top level of the pipelined signed integer alu
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_ready   | in_item_t
//  out     | output    | out_valid/out_ready | out_item_t
// the path from input transfer to out_valid runs through the decode register,
// one stage per quotient bit and the sign fix into the output register; one transfer per cycle unless the output stalls
// reset clears all valid bits; payload registers are not reset
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
`default_nettype none
module signed_integer_alu_core
  import siau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic      en;
  logic      s0_valid;
  div_work_t s0_work;
  div_work_t s0_next;
  logic      dp_valid;
  div_work_t dp_work;
  logic      s2_valid;
  out_item_t s2_next;
  logic [DataWidth-1:0]   prod;
  logic [DataWidth-1:0]   a, b, ma, mb;
  logic                   neg_a, neg_b;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // operand decode and simple ops
  always_comb begin
    a = in_data.operand_a;
    b = in_data.operand_b;
    neg_a = a[DataWidth-1];
    neg_b = b[DataWidth-1];
    ma = neg_a ? (~a + 1'b1) : a;
    mb = neg_b ? (~b + 1'b1) : b;
    prod = a * b;
    s0_next = '0;
    s0_next.use_alt = 1'b1;
    s0_next.status = ST_OK;
    case (op_t'(in_data.operation))
      OP_ADD: s0_next.alt = a + b;
      OP_SUB: s0_next.alt = a - b;
      OP_MUL: s0_next.alt = prod;
      OP_AND: s0_next.alt = a & b;
      OP_OR:  s0_next.alt = a | b;
      OP_NOT: s0_next.alt = ~a;
      OP_XOR: s0_next.alt = a ^ b;
      OP_INC: s0_next.alt = a + 1'b1;
      OP_DEC: s0_next.alt = a - 1'b1;
      OP_DIV, OP_REM: begin
        s0_next.is_div = (in_data.operation == OP_DIV);
        if (b == '0) begin
          s0_next.status = ST_DIV0;
        end else if (a == {1'b1, {(DataWidth-1){1'b0}}} && b == '1) begin
          s0_next.status = ST_OVERFLOW;
          s0_next.alt = s0_next.is_div ? a : '0;
        end else begin
          s0_next.use_alt = 1'b0;
          s0_next.quo = ma;
          s0_next.dvs = mb;
          s0_next.neg_q = neg_a ^ neg_b;
          s0_next.neg_r = neg_a;
        end
      end
      default: s0_next.status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s0_work <= s0_next;
  end

  siau_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_valid),
    .in_work  (s0_work),
    .out_valid(dp_valid),
    .out_work (dp_work)
  );

  // sign fix of quotient and remainder, or pass-through of the simple op result
  always_comb begin
    s2_next.status = dp_work.status;
    if (dp_work.use_alt) begin
      s2_next.result = dp_work.alt;
    end else if (dp_work.is_div) begin
      s2_next.result = dp_work.neg_q ? (~dp_work.quo + 1'b1) : dp_work.quo;
    end else begin
      s2_next.result = dp_work.neg_r ? (~dp_work.rem + 1'b1) : dp_work.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= s2_next;
  end

  assign out_valid = s2_valid;
endmodule
`default_nettype wire

// ===== sv/siau_checker.sv =====
// port-level checker for the signed integer alu, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module siau_checker
  import siau_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_ready
);
  logic err_code;

  assign err_code = (out_data.status == ST_DIV0) || (out_data.status == ST_INVALID);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_ready_free, clk, rst, !out_valid, in_ready)
  `ASSERT_IMPL(a_stall_ready, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && err_code, out_data.result == '0)
endmodule

bind signed_integer_alu_core siau_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

// ===== tb/sv/signed_integer_alu_core_tb.sv =====
// testbench for the signed integer alu: random and directed items checked against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_alu_core_tb;
  import siau_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  signed_integer_alu_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam int CycleLimit = 400000;
  localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};

  out_item_t pending_results[$];
  int sender_idle_pct;
  int receiver_idle_pct;
  int mismatches;
  int items_sent;
  int results_seen;
  int cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_item_t alu_predict(in_item_t item);
    out_item_t o;
    logic [DataWidth-1:0] a, b, ma, mb, q, r;
    a = item.operand_a;
    b = item.operand_b;
    o.status = ST_OK;
    o.result = '0;
    case (item.operation)
      OP_ADD: o.result = a + b;
      OP_SUB: o.result = a - b;
      OP_MUL: o.result = a * b;
      OP_AND: o.result = a & b;
      OP_OR:  o.result = a | b;
      OP_NOT: o.result = ~a;
      OP_XOR: o.result = a ^ b;
      OP_INC: o.result = a + 1'b1;
      OP_DEC: o.result = a - 1'b1;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          o.status = ST_DIV0;
        end else if (a == MinVal && b == '1) begin
          o.status = ST_OVERFLOW;
          o.result = (item.operation == OP_DIV) ? a : '0;
        end else begin
          ma = a[DataWidth-1] ? -a : a;
          mb = b[DataWidth-1] ? -b : b;
          q = ma / mb;
          r = ma % mb;
          if (item.operation == OP_DIV) begin
            o.result = (a[DataWidth-1] != b[DataWidth-1]) ? -q : q;
          end else begin
            o.result = a[DataWidth-1] ? -r : r;
          end
        end
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  task automatic send_item(input logic [3:0] op, input logic [DataWidth-1:0] a,
                           input logic [DataWidth-1:0] b);
    in_item_t item;
    item.operation = op;
    item.operand_a = a;
    item.operand_b = b;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_results.push_back(alu_predict(item));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transfer: result %h status %0d", out_data.result,
                   out_data.status);
        end
      end else begin
        automatic out_item_t want = pending_results.pop_front();
        if (want.result !== out_data.result || want.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %h/%0d got %h/%0d", want.result, want.status,
                     out_data.result, out_data.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("signed_integer_alu_core_tb: errors");
      $finish;
    end
  end

  function automatic logic [DataWidth-1:0] rand_operand();
    case ($urandom_range(9))
      0: return MinVal;
      1: return MaxVal;
      2: return '1;
      3: return '0;
      4: return DataWidth'($urandom_range(8));
      5: return -DataWidth'($urandom_range(8));
      6: return DataWidth'($urandom_range(4000)) - 2000;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_directed();
    logic [3:0] op;
    for (int k = 0; k < 16; k++) begin
      op = 4'(k);
      send_item(op, MinVal, MaxVal);
    end
    send_item(OP_DIV, 32'd7, '0);
    send_item(OP_REM, MinVal, '0);
    send_item(OP_DIV, MinVal, '1);
    send_item(OP_REM, MinVal, '1);
    send_item(OP_DIV, -32'sd7, 32'sd2);
    send_item(OP_REM, -32'sd7, 32'sd2);
    send_item(OP_REM, 32'sd7, -32'sd2);
    send_item(OP_INC, MaxVal, '1);
    send_item(OP_DEC, MinVal, '0);
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_item(4'($urandom_range(15)), rand_operand(), rand_operand());
      if (k == count / 2) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    sender_idle_pct = 23;
    receiver_idle_pct = 45;
    test_random(310);
    sender_idle_pct = 45;
    receiver_idle_pct = 23;
    test_random(310);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random(310);

    wait_drained();
    repeat (Stages + 10) @(negedge clk);
    $display("sent %0d items over all 16 codes, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("covered wrap, divide by zero, min over minus one and invalid codes");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("signed_integer_alu_core_tb: clean");
    end else begin
      $display("signed_integer_alu_core_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/siau_pkg.sv
sv/siau_div_pipe.sv
sv/signed_integer_alu_core.sv
sv/siau_checker.sv
tb/sv/signed_integer_alu_core_tb.sv
